// ----- hdl/dshsf_pkg.sv -----
// shared types and constants for the dual sensor heading and speed fusion core
`timescale 1ns / 1ps
`default_nettype none

package dshsf_pkg;

	// field widths
	localparam int HEAD_W  = 10;
	localparam int CONF_W  = 8;
	localparam int SPEED_W = 16;
	localparam int STILL_W = 16;
	localparam int PROJ_W  = 9;

	// packed stream widths
	localparam int IN_DATA_W  = 104;
	localparam int OUT_DATA_W = 40;

	// arithmetic widths of the speed path
	localparam int ACC_W = SPEED_W + CONF_W + 1;
	localparam int NUM_W = SPEED_W + CONF_W;
	localparam int TOT_W = CONF_W + 1;
	localparam int REM_W = CONF_W + 2;
	localparam int CNT_W = 5;

	// shift-add and divide step counts
	localparam logic [CNT_W-1:0] MUL_STEPS = CNT_W'(CONF_W);
	localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(NUM_W);

	// heading constants
	localparam logic signed [HEAD_W:0] QUARTER_TURN = 11'sd90;
	localparam logic signed [HEAD_W:0] FULL_TURN    = 11'sd360;
	localparam logic signed [HEAD_W:0] TWO_TURNS    = 11'sd720;
	localparam logic signed [HEAD_W+1:0] SLEW_LIMIT = 12'sd10;
	localparam logic [STILL_W-1:0] STILL_LIMIT      = 16'd10;
	localparam logic signed [HEAD_W-1:0] NO_HEADING = -10'sd1;
	localparam logic signed [SPEED_W-1:0] NO_SPEED  = -16'sd1;

	// configuration register indexes
	localparam logic REG_TWO_SENSORS = 1'b0;
	localparam logic REG_CLOCKWISE   = 1'b1;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_ABS,
		ST_DIV
	} state_t;

	typedef enum logic {
		PH_RUN,
		PH_DONE
	} phase_t;

endpackage

`default_nettype wire

// ----- hdl/dual_sensor_heading_speed_fusion_core.sv -----
// top level of the dual sensor heading and speed fusion core
//
// channel   dir   handshake          payload
// s_axis    in    s_tvalid/s_tready  s_tdata: both sensors' readings of one frame
// m_axis    out   m_tvalid/m_tready  m_tdata: fused result, m_tuser: second_view
// cfg       in    cfg_we             cfg_idx, cfg_data
//
// a word in single-sensor mode or with a speed bypass case is loaded into the output
// register once the output is free; a fused weighted speed first runs 8 shift-add steps of
// the serial multiplier, a magnitude step and 24 restoring divide steps before the load
// the next word is taken only after that load, so the core works on one word at a time
// reset sets two_sensors to 0, clockwise to 1 and clears the previous heading
// a stalled output holds its word while the next word is being worked on
`timescale 1ns / 1ps
`default_nettype none

module dual_sensor_heading_speed_fusion_core (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// configuration
	input  wire logic                              cfg_we,
	input  wire logic                              cfg_idx,
	input  wire logic                              cfg_data,
	// input stream
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	// heading_a, heading_conf_a, speed_a, speed_conf_a, still_frames_a,
	// heading_b, heading_conf_b, speed_b, speed_conf_b, zero pad
	input  wire logic [dshsf_pkg::IN_DATA_W-1:0]   s_tdata,
	// output stream
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// fused_heading, fused_speed, projected_heading_b, still_flag, zero pad
	output logic [dshsf_pkg::OUT_DATA_W-1:0]       m_tdata,
	// second_view
	output logic                                   m_tuser
);

	localparam int HW = dshsf_pkg::HEAD_W;
	localparam int CW = dshsf_pkg::CONF_W;
	localparam int SW = dshsf_pkg::SPEED_W;
	localparam int AW = dshsf_pkg::ACC_W;
	localparam int NW = dshsf_pkg::NUM_W;
	localparam int TW = dshsf_pkg::TOT_W;
	localparam int RW = dshsf_pkg::REM_W;
	localparam int KW = dshsf_pkg::CNT_W;

	// unpacked input fields
	logic signed [HW-1:0] heading_a, heading_b;
	logic [CW-1:0]        heading_conf_a, heading_conf_b, speed_conf_a, speed_conf_b;
	logic signed [SW-1:0] speed_a, speed_b;
	logic [dshsf_pkg::STILL_W-1:0] still_frames_a;

	assign heading_a      = s_tdata[9:0];
	assign heading_conf_a = s_tdata[17:10];
	assign speed_a        = s_tdata[33:18];
	assign speed_conf_a   = s_tdata[41:34];
	assign still_frames_a = s_tdata[57:42];
	assign heading_b      = s_tdata[67:58];
	assign heading_conf_b = s_tdata[75:68];
	assign speed_b        = s_tdata[91:76];
	assign speed_conf_b   = s_tdata[99:92];

	// configuration registers
	logic two_sensors_q, clockwise_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			two_sensors_q <= 1'b0;
			clockwise_q   <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_idx)
				dshsf_pkg::REG_TWO_SENSORS: two_sensors_q <= cfg_data;
				dshsf_pkg::REG_CLOCKWISE:   clockwise_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// sensor two heading rotated and wrapped into 0..359
	logic signed [HW:0] proj_sum, proj_wrap;

	always_comb begin
		proj_sum = {heading_b[HW-1], heading_b} +
			(clockwise_q ? dshsf_pkg::QUARTER_TURN : -dshsf_pkg::QUARTER_TURN);
		if (proj_sum < -dshsf_pkg::FULL_TURN)
			proj_wrap = proj_sum + dshsf_pkg::TWO_TURNS;
		else if (proj_sum < 0)
			proj_wrap = proj_sum + dshsf_pkg::FULL_TURN;
		else if (proj_sum >= dshsf_pkg::FULL_TURN)
			proj_wrap = proj_sum - dshsf_pkg::FULL_TURN;
		else
			proj_wrap = proj_sum;
	end

	// heading choice by confidence, then slew limit against the previous heading
	logic                 a_absent, b_absent;
	logic signed [HW-1:0] head_pick, head_slew;
	logic signed [HW+1:0] head_diff;
	logic signed [HW-1:0] last_heading_q;

	always_comb begin
		a_absent = (heading_a == dshsf_pkg::NO_HEADING);
		b_absent = (heading_b == dshsf_pkg::NO_HEADING);
		if (a_absent)
			head_pick = b_absent ? dshsf_pkg::NO_HEADING : proj_wrap[HW-1:0];
		else if (b_absent)
			head_pick = heading_a;
		else
			head_pick = (heading_conf_a > heading_conf_b) ? heading_a : proj_wrap[HW-1:0];

		head_diff = {{2{last_heading_q[HW-1]}}, last_heading_q} -
			{{2{head_pick[HW-1]}}, head_pick};
		head_slew = head_pick;
		if (last_heading_q != dshsf_pkg::NO_HEADING) begin
			if (head_diff > dshsf_pkg::SLEW_LIMIT)
				head_slew = last_heading_q - HW'(dshsf_pkg::SLEW_LIMIT);
			else if (head_diff < -dshsf_pkg::SLEW_LIMIT)
				head_slew = last_heading_q + HW'(dshsf_pkg::SLEW_LIMIT);
		end
	end

	// speed cases that need no division
	logic                 spd_bypass;
	logic signed [SW-1:0] spd_direct;

	always_comb begin
		spd_bypass = 1'b1;
		spd_direct = speed_a;
		if (two_sensors_q) begin
			if (speed_a == dshsf_pkg::NO_SPEED)
				spd_direct = speed_b;
			else if (speed_b == dshsf_pkg::NO_SPEED)
				spd_direct = speed_a;
			else if (speed_conf_a == '0 && speed_conf_b == '0)
				spd_direct = speed_a;
			else
				spd_bypass = 1'b0;
		end
	end

	// sequencer
	dshsf_pkg::state_t state_q, state_nxt;
	dshsf_pkg::phase_t phase_q, phase_nxt;
	logic [KW-1:0]     cnt_q;
	logic              in_take, out_free, finish;

	assign in_take  = s_tvalid && s_tready;
	assign out_free = !m_tvalid || m_tready;

	// next state
	always_comb begin
		state_nxt = state_q;
		phase_nxt = phase_q;
		case (state_q)
			dshsf_pkg::ST_IDLE: begin
				if (phase_q == dshsf_pkg::PH_DONE) begin
					if (out_free)
						phase_nxt = dshsf_pkg::PH_RUN;
				end else if (in_take) begin
					if (spd_bypass)
						phase_nxt = dshsf_pkg::PH_DONE;
					else
						state_nxt = dshsf_pkg::ST_MUL;
				end
			end
			dshsf_pkg::ST_MUL: begin
				if (cnt_q == dshsf_pkg::MUL_STEPS - 1'b1)
					state_nxt = dshsf_pkg::ST_ABS;
			end
			dshsf_pkg::ST_ABS: state_nxt = dshsf_pkg::ST_DIV;
			dshsf_pkg::ST_DIV: begin
				if (cnt_q == dshsf_pkg::DIV_STEPS - 1'b1) begin
					state_nxt = dshsf_pkg::ST_IDLE;
					phase_nxt = dshsf_pkg::PH_DONE;
				end
			end
			default: state_nxt = dshsf_pkg::ST_IDLE;
		endcase
	end

	// handshake outputs of the sequencer
	always_comb begin
		s_tready = 1'b0;
		finish   = 1'b0;
		case (state_q)
			dshsf_pkg::ST_IDLE: begin
				s_tready = (phase_q == dshsf_pkg::PH_RUN);
				finish   = (phase_q == dshsf_pkg::PH_DONE) && out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dshsf_pkg::ST_IDLE;
			phase_q <= dshsf_pkg::PH_RUN;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nxt;
			phase_q <= phase_nxt;
			if (state_q != state_nxt)
				cnt_q <= '0;
			else
				cnt_q <= cnt_q + 1'b1;
		end
	end

	// previous heading, kept only in two-sensor mode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			last_heading_q <= dshsf_pkg::NO_HEADING;
		else if (in_take && two_sensors_q)
			last_heading_q <= head_slew;
	end

	// fields of the word in flight
	logic signed [HW-1:0] head_q;
	logic signed [SW-1:0] spd_q;
	logic [dshsf_pkg::PROJ_W-1:0] proj_q;
	logic still_q, second_q, use_div_q;

	always_ff @(posedge clk) begin
		if (in_take) begin
			head_q    <= two_sensors_q ? head_slew : heading_a;
			spd_q     <= spd_direct;
			proj_q    <= two_sensors_q ? proj_wrap[dshsf_pkg::PROJ_W-1:0] : '0;
			still_q   <= (still_frames_a > dshsf_pkg::STILL_LIMIT);
			second_q  <= two_sensors_q;
			use_div_q <= !spd_bypass;
		end
	end

	// serial shift-add multiply, magnitude and restoring divide
	logic signed [AW-1:0] acc_q, ma_q, mb_q;
	logic [CW-1:0]        ca_q, cb_q;
	logic [TW-1:0]        tot_q;
	logic [NW-1:0]        num_q;
	logic [RW-1:0]        rem_q;
	logic [SW-1:0]        quo_q;
	logic                 neg_q;
	logic [RW:0]          trial;
	logic signed [AW-1:0] part_a, part_b;

	assign part_a = ca_q[0] ? ma_q : '0;
	assign part_b = cb_q[0] ? mb_q : '0;
	assign trial  = {rem_q, num_q[NW-1]} - {2'b00, tot_q};

	always_ff @(posedge clk) begin
		case (state_q)
			dshsf_pkg::ST_IDLE: begin
				acc_q <= '0;
				ma_q  <= AW'(speed_a);
				mb_q  <= AW'(speed_b);
				ca_q  <= speed_conf_a;
				cb_q  <= speed_conf_b;
				tot_q <= {1'b0, speed_conf_a} + {1'b0, speed_conf_b};
			end
			dshsf_pkg::ST_MUL: begin
				acc_q <= acc_q + part_a + part_b;
				ma_q  <= ma_q <<< 1;
				mb_q  <= mb_q <<< 1;
				ca_q  <= ca_q >> 1;
				cb_q  <= cb_q >> 1;
			end
			dshsf_pkg::ST_ABS: begin
				neg_q <= acc_q[AW-1];
				num_q <= acc_q[AW-1] ? NW'(-acc_q) : NW'(acc_q);
				rem_q <= '0;
				quo_q <= '0;
			end
			dshsf_pkg::ST_DIV: begin
				num_q <= num_q << 1;
				if (!trial[RW]) begin
					rem_q <= trial[RW-1:0];
					quo_q <= {quo_q[SW-2:0], 1'b1};
				end else begin
					rem_q <= {rem_q[RW-2:0], num_q[NW-1]};
					quo_q <= {quo_q[SW-2:0], 1'b0};
				end
			end
			default: ;
		endcase
	end

	// output register
	logic [dshsf_pkg::OUT_DATA_W-1:0] out_data_q;
	logic                             out_user_q, out_valid_q;
	logic signed [SW-1:0]             spd_final;

	assign spd_final = use_div_q ? (neg_q ? -$signed(quo_q) : $signed(quo_q)) : spd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (finish)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			out_data_q <= {4'b0000, still_q, proj_q, spd_final, head_q};
			out_user_q <= second_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

endmodule

`default_nettype wire
